[rtl/mexp_pkg.sv]
// Package for the modular exponentiation core.
// Holds the default operand width shared by the top level and the multiplier.
// No dependencies.
package mexp_pkg;

   localparam int OPERAND_BITS_DEF = 32;

endpackage

[rtl/mexp_mulmod.sv]
// Bit-serial modular multiplier: prod = (a * b) mod m, one bit of b per cycle, MSB first.
// Requires a < m and m > 0. Depends on mexp_pkg.
module mexp_mulmod
   import mexp_pkg::*;
#(
   parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    go,
   input  logic [OPERAND_BITS-1:0] a,
   input  logic [OPERAND_BITS-1:0] b,
   input  logic [OPERAND_BITS-1:0] m,
   output logic                    done,
   output logic [OPERAND_BITS-1:0] prod
);

   localparam int CW = $clog2(OPERAND_BITS);

   logic                    run_ff, run_in;
   logic                    done_ff, done_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [OPERAND_BITS-1:0] a_ff, a_in;
   logic [OPERAND_BITS-1:0] b_ff, b_in;
   logic [OPERAND_BITS-1:0] m_ff, m_in;
   logic [OPERAND_BITS-1:0] r_ff, r_in;

   logic [OPERAND_BITS:0]   dbl;
   logic [OPERAND_BITS:0]   dbl_red;
   logic [OPERAND_BITS:0]   sum;
   logic [OPERAND_BITS:0]   sum_red;

   // One step: double the partial remainder, then add a if the current bit of b is set
   always_comb begin
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m_ff}) ? (dbl - {1'b0, m_ff}) : dbl;
      sum     = {1'b0, dbl_red[OPERAND_BITS-1:0]} +
                (b_ff[OPERAND_BITS-1] ? {1'b0, a_ff} : '0);
      sum_red = (sum >= {1'b0, m_ff}) ? (sum - {1'b0, m_ff}) : sum;
   end

   // Load operands on go, advance one bit per cycle while running
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      r_in    = r_ff;
      if (go) begin
         run_in = 1'b1;
         cnt_in = CW'(OPERAND_BITS - 1);
         a_in   = a;
         b_in   = b;
         m_in   = m;
         r_in   = '0;
      end else if (run_ff) begin
         r_in   = sum_red[OPERAND_BITS-1:0];
         b_in   = {b_ff[OPERAND_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      m_ff <= m_in;
      r_ff <= r_in;
   end

   assign done = done_ff;
   assign prod = r_ff;

`ifndef ASSERT_OFF
   // The sequencer never launches a product while one is in flight
   assert property (@(posedge clock) disable iff (reset) go |-> !run_ff)
      else $error("mexp_mulmod: go while running");

   // A finished product is fully reduced
   assert property (@(posedge clock) disable iff (reset) done_ff |-> (r_ff < m_ff))
      else $error("mexp_mulmod: product not reduced");

   // Completion is a single-cycle pulse
   assert property (@(posedge clock) disable iff (reset) done_ff |=> !done_ff)
      else $error("mexp_mulmod: done held for more than one cycle");
`endif

endmodule

[rtl/modular_exponentiation_core.sv]
// Modular exponentiation core: base^exponent mod modulus, right-to-left square-and-multiply.
// Each modular product runs on the one shared bit-serial multiplier; an item needs
// 1 + OPERAND_BITS + popcount(exponent) products: one to reduce the base, a square for
// every exponent bit and a multiply for every set bit. A zero modulus skips the multiplier
// and gives a flagged zero result from the done state.
// One item at a time: the next item is accepted at the edge that takes the result.
// Synchronous active-high reset returns the sequencer to idle; the receiver cannot stall.
module modular_exponentiation_core
   import mexp_pkg::*;
#(
   parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [OPERAND_BITS-1:0] req_base,
   input  logic [OPERAND_BITS-1:0] req_exponent,
   input  logic [OPERAND_BITS-1:0] req_modulus,
   output logic                    rsp_valid,
   output logic [OPERAND_BITS-1:0] rsp_power_result,
   output logic                    rsp_bad_modulus
);

   localparam int CW = $clog2(OPERAND_BITS);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_RED  = 5'b00010,
      S_MUL  = 5'b00100,
      S_SQR  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic                    go_ff, go_in;
   logic [CW-1:0]           bit_cnt_ff, bit_cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OPERAND_BITS-1:0] exp_ff, exp_in;
   logic [OPERAND_BITS-1:0] mod_ff, mod_in;
   logic [OPERAND_BITS-1:0] sq_ff, sq_in;
   logic [OPERAND_BITS-1:0] acc_ff, acc_in;
   logic                    bad_ff, bad_in;
   logic [OPERAND_BITS-1:0] rsp_result_ff, rsp_result_in;
   logic                    rsp_bad_ff, rsp_bad_in;

   logic                    mul_done;
   logic [OPERAND_BITS-1:0] mul_prod;
   logic [OPERAND_BITS-1:0] mul_a;
   logic [OPERAND_BITS-1:0] mul_b;

   // Pick multiplier operands: reduce the base, multiply into acc, or square
   always_comb begin
      case (state_ff)
         S_RED: begin
            mul_a = OPERAND_BITS'(1);
            mul_b = sq_ff;
         end
         S_MUL: begin
            mul_a = acc_ff;
            mul_b = sq_ff;
         end
         default: begin
            mul_a = sq_ff;
            mul_b = sq_ff;
         end
      endcase
   end

   mexp_mulmod #(
      .OPERAND_BITS(OPERAND_BITS)
   ) u_mulmod (
      .clock (clock),
      .reset (reset),
      .go    (go_ff),
      .a     (mul_a),
      .b     (mul_b),
      .m     (mod_ff),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   // Sequencer: reduce the base, then for each exponent bit, LSB first, an optional multiply and a square
   always_comb begin
      state_in      = state_ff;
      go_in         = 1'b0;
      bit_cnt_in    = bit_cnt_ff;
      rsp_valid_in  = 1'b0;
      exp_in        = exp_ff;
      mod_in        = mod_ff;
      sq_in         = sq_ff;
      acc_in        = acc_ff;
      bad_in        = bad_ff;
      rsp_result_in = rsp_result_ff;
      rsp_bad_in    = rsp_bad_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               exp_in     = req_exponent;
               mod_in     = req_modulus;
               sq_in      = req_base;
               acc_in     = OPERAND_BITS'(req_modulus != OPERAND_BITS'(1));
               bit_cnt_in = '0;
               if (req_modulus == '0) begin
                  bad_in   = 1'b1;
                  state_in = S_DONE;
               end else begin
                  bad_in   = 1'b0;
                  go_in    = 1'b1;
                  state_in = S_RED;
               end
            end
         end
         S_RED: begin
            if (mul_done) begin
               sq_in    = mul_prod;
               go_in    = 1'b1;
               state_in = exp_ff[0] ? S_MUL : S_SQR;
            end
         end
         S_MUL: begin
            if (mul_done) begin
               acc_in   = mul_prod;
               go_in    = 1'b1;
               state_in = S_SQR;
            end
         end
         S_SQR: begin
            if (mul_done) begin
               sq_in      = mul_prod;
               exp_in     = exp_ff >> 1;
               bit_cnt_in = bit_cnt_ff + 1'b1;
               if (bit_cnt_ff == CW'(OPERAND_BITS - 1)) begin
                  state_in = S_DONE;
               end else begin
                  go_in    = 1'b1;
                  state_in = exp_ff[1] ? S_MUL : S_SQR;
               end
            end
         end
         S_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_result_in = bad_ff ? '0 : acc_ff;
            rsp_bad_in    = bad_ff;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         go_ff        <= 1'b0;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff        <= exp_in;
      mod_ff        <= mod_in;
      sq_ff         <= sq_in;
      acc_ff        <= acc_in;
      bad_ff        <= bad_in;
      rsp_result_ff <= rsp_result_in;
      rsp_bad_ff    <= rsp_bad_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_result_ff;
   assign rsp_bad_modulus  = rsp_bad_ff;

`ifndef ASSERT_OFF
   // A result item is delivered only once the sequencer is back in idle
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("modular_exponentiation_core: result while busy");

   // A zero modulus is answered through the done state with the error flag
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_modulus == '0)) |-> ##2 (rsp_valid && rsp_bad_modulus))
      else $error("modular_exponentiation_core: zero modulus not flagged");

   // A flagged item carries a zero power result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_modulus) |-> (rsp_power_result == '0))
      else $error("modular_exponentiation_core: flagged result not zero");
`endif

endmodule
